@@ rtl/kmsq_pkg.sv @@
package kmsq_pkg;

	localparam int RING_SLOTS  = 32;
	localparam int MATRIX_ROWS = 11;

	localparam int RING_W     = $clog2(RING_SLOTS);
	localparam int KEYS       = MATRIX_ROWS * 8;
	localparam int KEY_W      = $clog2(KEYS);
	localparam int INPUT_KEYS = 88;
	localparam int COUNT_W    = 5;

	localparam logic [1:0] OP_SCAN         = 2'd0;
	localparam logic [1:0] OP_PORT_A_READ  = 2'd1;
	localparam logic [1:0] OP_PORT_B_WRITE = 2'd2;

	localparam logic [7:0] RELEASE_MASK = 8'h80;
	localparam logic [7:0] SWITCH_RESET = 8'd101;
	localparam int         SELECT_BIT   = 7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_LATCH,
		ST_DONE
	} kmsq_state_t;

	typedef struct packed {
		logic       push;
		logic [7:0] code;
		logic       pop;
	} ring_ctl_t;

	typedef struct packed {
		logic               empty;
		logic [COUNT_W-1:0] count;
		logic [7:0]         head_code;
	} ring_sts_t;

endpackage

@@ rtl/kmsq_ring.sv @@
module kmsq_ring
	import kmsq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  ring_ctl_t ctl,
	output ring_sts_t sts
);

	logic [7:0]        mem [RING_SLOTS];
	logic [RING_W-1:0] head_q;
	logic [RING_W-1:0] tail_q;
	logic [RING_W-1:0] head_nx;
	logic [RING_W-1:0] tail_nx;
	logic [7:0]        rd_q;
	logic [RING_W:0]   used;
	logic [RING_W+COUNT_W:0] used_ext;
	logic              full;

	assign head_nx = (head_q == RING_W'(RING_SLOTS - 1)) ? '0 : head_q + RING_W'(1);
	assign tail_nx = (tail_q == RING_W'(RING_SLOTS - 1)) ? '0 : tail_q + RING_W'(1);
	assign full    = (tail_nx == head_q);

	always_comb begin
		if (tail_q >= head_q) begin
			used = {1'b0, tail_q} - {1'b0, head_q};
		end else begin
			used = {1'b0, tail_q} + (RING_W+1)'(RING_SLOTS) - {1'b0, head_q};
		end
		used_ext = (RING_W+COUNT_W+1)'(used);
	end

	always_ff @(posedge clk) begin
		if (ctl.push && !full) begin
			mem[tail_q] <= ctl.code;
		end
		rd_q <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
		end else begin
			if (ctl.push && !full) begin
				tail_q <= tail_nx;
			end
			if (ctl.pop) begin
				head_q <= head_nx;
			end
		end
	end

	assign sts.empty     = (head_q == tail_q);
	assign sts.count     = used_ext[COUNT_W-1:0];
	assign sts.head_code = rd_q;

endmodule

@@ rtl/key_matrix_scancode_queue.sv @@
// a scan walks the matrix one key per cycle through a single shift-and-compare step,
// then passes through the fetch, latch and done states before its result is loaded
// port A read, port B write and the unused op go from idle straight to the done state
// one item at a time: a new input beat is taken once the result is in the output register
// reset: async active low, clears key state, ring pointers, latch and interrupt,
// sets switch select and loads the switch byte with 101; ring storage is not cleared
module key_matrix_scancode_queue
	import kmsq_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_wr_en,
	input  logic [7:0]   cfg_wr_data,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [1:0]   op,
	input  logic [63:0]  key_rows_low,
	input  logic [23:0]  key_rows_high,
	input  logic [7:0]   port_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [7:0]   read_data,
	output logic         irq_level,
	output logic [COUNT_W-1:0] queue_count
);

	kmsq_state_t state_q, state_nx;

	logic [KEYS+INPUT_KEYS-1:0] keys_ext;
	logic [KEYS-1:0]  keys_in;
	logic [KEYS-1:0]  now_q;
	logic [KEYS-1:0]  ks_q;
	logic [KEY_W-1:0] key_idx_q;
	logic [7:0]       sw_q;
	logic [7:0]       latched_q;
	logic [7:0]       rd_pend_q;
	logic             irq_q;
	logic             sel_q;
	logic             out_valid_q;
	logic [7:0]       out_data_q;
	logic             out_irq_q;
	logic [COUNT_W-1:0] out_count_q;
	logic             in_beat;
	logic             out_load;
	logic             latch_go;
	logic             last_key;
	logic [7:0]       code_base;
	ring_ctl_t        ring_ctl;
	ring_sts_t        ring_sts;

	assign keys_ext  = {{KEYS{1'b0}}, key_rows_high, key_rows_low};
	assign keys_in   = keys_ext[KEYS-1:0];
	assign in_beat   = in_valid && in_ready;
	assign last_key  = (key_idx_q == KEY_W'(KEYS - 1));
	assign code_base = 8'(key_idx_q) + 8'd1;
	assign latch_go  = !irq_q && !ring_sts.empty && !sel_q;

	kmsq_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.sts    (ring_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		in_ready      = 1'b0;
		out_load      = 1'b0;
		ring_ctl.push = 1'b0;
		ring_ctl.pop  = 1'b0;
		ring_ctl.code = code_base | (now_q[0] ? 8'h00 : RELEASE_MASK);
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nx = (op == OP_SCAN) ? ST_SCAN : ST_DONE;
				end
			end
			ST_SCAN: begin
				ring_ctl.push = now_q[0] ^ ks_q[0];
				if (last_key) begin
					state_nx = ST_FETCH;
				end
			end
			ST_FETCH: begin
				state_nx = ST_LATCH;
			end
			ST_LATCH: begin
				ring_ctl.pop = latch_go;
				state_nx     = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q        <= '0;
			key_idx_q   <= '0;
			sw_q        <= SWITCH_RESET;
			latched_q   <= '0;
			irq_q       <= 1'b0;
			sel_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				sw_q <= cfg_wr_data;
			end
			if (in_beat) begin
				key_idx_q <= '0;
				unique case (op)
					OP_PORT_A_READ: begin
						if (!sel_q) begin
							irq_q <= 1'b0;
						end
					end
					OP_PORT_B_WRITE: begin
						sel_q <= port_data[SELECT_BIT];
					end
					default: begin
					end
				endcase
			end
			if (state_q == ST_SCAN) begin
				ks_q      <= {now_q[0], ks_q[KEYS-1:1]};
				key_idx_q <= key_idx_q + KEY_W'(1);
			end
			if (state_q == ST_LATCH && latch_go) begin
				latched_q <= ring_sts.head_code;
				irq_q     <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_beat) begin
			now_q <= keys_in;
			if (op == OP_PORT_A_READ) begin
				rd_pend_q <= sel_q ? sw_q : latched_q;
			end else begin
				rd_pend_q <= 8'h00;
			end
		end else if (state_q == ST_SCAN) begin
			now_q <= {1'b0, now_q[KEYS-1:1]};
		end
		if (out_load) begin
			out_data_q  <= rd_pend_q;
			out_irq_q   <= irq_q;
			out_count_q <= ring_sts.count;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_data_q;
	assign irq_level   = out_irq_q;
	assign queue_count = out_count_q;

endmodule

@@ rtl/kmsq_checker.sv @@
module kmsq_checker
	import kmsq_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         op,
	input logic               out_valid,
	input logic               out_ready,
	input logic [7:0]         read_data,
	input logic               irq_level,
	input logic [COUNT_W-1:0] queue_count
);

	// a result beat waiting for the sink keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(read_data)
			&& $stable(irq_level) && $stable(queue_count))
		else $error("result beat changed while stalled");

	// one item at a time
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// a scan keeps the input closed while it walks the matrix
	a_scan_long: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && op == OP_SCAN |=> ##1 !in_ready)
		else $error("scan finished too early");

	// a result is only loaded while no input beat can be taken
	a_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result loaded while idle");

endmodule

bind key_matrix_scancode_queue kmsq_checker u_kmsq_checker (.*);
